// ----- src/crc16_checked_frame_deframer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared helpers for the concurrent checks in the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef CRC16_CHECKED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define CRC16_CHECKED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CRCDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset.
`define CRCDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ----- src/crcdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Deframer package
// Result record, status codes and the CRC-16/ARC byte step.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    localparam logic [7:0]  MARKER_BYTE     = 8'h3E;
    localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [7:0]  frame_topic;
        logic [7:0]  sequence_res;
        logic [15:0] frame_len;
    } result_t;

    // One byte of reflected CRC-16 (LSB first).
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- src/crc16_checked_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// CRC-16 checked frame deframer
// Serial byte stream in, payload bytes and frame status out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with one received byte per item (in_byte).
// Output channel: out_valid/out_ready; a result item carries a payload byte
// (byte_valid) and/or a frame end with frame_status, plus the header's
// topic, sequence and length. Marker and header bytes produce no result, except
// that the last header byte closes an empty or oversize frame.
// Config: cfg_we/cfg_wdata writes max_payload; write only while the block is idle.
// Path: an accepted byte sits in the input register while it is processed;
// its result enters the output register at the edge where the byte is taken.
// Throughput: one byte per cycle while the output is not stalled, set by the state
// update and CRC byte step between the input and result registers.
// Reset: hunting for the ">>>" marker, all header fields zero, max_payload
// 1024, both channel registers empty.
// Stall: while the output register is full and out_ready is low, a byte that
// would give a result waits in the input register and in_ready drops; bytes
// giving no result still flow.
// ----------------------------------------------------------------------------
module crc16_checked_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        frame_end,
    output logic [1:0]  frame_status,
    output logic [7:0]  frame_topic,
    output logic [7:0]  sequence_res,
    output logic [15:0] frame_len
);

    logic               item_valid;
    logic [7:0]         item_byte;
    logic               take;
    logic               emit;
    logic               out_free;
    crcdf_pkg::result_t core_result;
    crcdf_pkg::result_t out_data;

    assign take = item_valid && (!emit || out_free);

    crcdf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    crcdf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .take       (take),
        .emit       (emit),
        .result     (core_result)
    );

    crcdf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && emit),
        .load_data  (core_result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign out_byte       = out_data.out_byte;
    assign byte_valid     = out_data.byte_valid;
    assign frame_end      = out_data.frame_end;
    assign frame_status   = out_data.frame_status;
    assign frame_topic    = out_data.frame_topic;
    assign sequence_res   = out_data.sequence_res;
    assign frame_len      = out_data.frame_len;

endmodule

// ----- src/crcdf_in_stage.sv -----
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module crcdf_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

// ----- src/crcdf_core.sv -----
// ----------------------------------------------------------------------------
// Deframer frame logic
// Marker hunt, header capture, payload pass-through and CRC check.
// ----------------------------------------------------------------------------
`include "crc16_checked_frame_deframer_unit_defines.svh"

module crcdf_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    input  logic                  item_valid,
    input  logic [7:0]            item_byte,
    input  logic                  take,
    output logic                  emit,
    output crcdf_pkg::result_t    result
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TOPIC,
        PH_SEQ,
        PH_LENH,
        PH_LENL,
        PH_CRCH,
        PH_CRCL,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  marker_count_reg, marker_count_next;
    logic [7:0]  topic_reg, topic_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] max_payload_reg;

    logic        emit_raw;
    logic [15:0] crc_rx;
    logic [15:0] crc_calc;

    assign crc_rx   = {received_crc_reg[15:8], item_byte};
    assign crc_calc = crcdf_pkg::crc16_step(running_crc_reg, item_byte);
    assign emit     = item_valid && emit_raw;

    always_comb
    begin
        phase_next            = phase_reg;
        marker_count_next     = marker_count_reg;
        topic_next            = topic_reg;
        seq_next              = seq_reg;
        length_next           = length_reg;
        received_crc_next     = received_crc_reg;
        running_crc_next      = running_crc_reg;
        bytes_left_next       = bytes_left_reg;
        emit_raw              = 1'b0;
        result.out_byte       = 8'h00;
        result.byte_valid     = 1'b0;
        result.frame_end      = 1'b0;
        result.frame_status   = crcdf_pkg::STATUS_OK;
        result.frame_topic    = topic_reg;
        result.sequence_res   = seq_reg;
        result.frame_len      = length_reg;

        case (phase_reg)
            PH_HUNT:
            begin
                if (item_byte == crcdf_pkg::MARKER_BYTE)
                begin
                    if (marker_count_reg == 2'd2)
                    begin
                        marker_count_next = 2'd0;
                        phase_next        = PH_TOPIC;
                    end
                    else
                    begin
                        marker_count_next = marker_count_reg + 2'd1;
                    end
                end
                else
                begin
                    marker_count_next = 2'd0;
                end
            end
            PH_TOPIC:
            begin
                topic_next = item_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                seq_next   = item_byte;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                length_next = {item_byte, 8'h00};
                phase_next  = PH_LENL;
            end
            PH_LENL:
            begin
                length_next = {length_reg[15:8], item_byte};
                phase_next  = PH_CRCH;
            end
            PH_CRCH:
            begin
                received_crc_next = {item_byte, 8'h00};
                phase_next        = PH_CRCL;
            end
            PH_CRCL:
            begin
                received_crc_next = crc_rx;
                running_crc_next  = 16'h0000;
                if (length_reg > max_payload_reg)
                begin
                    phase_next          = PH_HUNT;
                    marker_count_next   = 2'd0;
                    emit_raw            = 1'b1;
                    result.frame_end    = 1'b1;
                    result.frame_status = crcdf_pkg::STATUS_OVERSIZE;
                end
                else if (length_reg == 16'd0)
                begin
                    phase_next          = PH_HUNT;
                    marker_count_next   = 2'd0;
                    emit_raw            = 1'b1;
                    result.frame_end    = 1'b1;
                    result.frame_status = (crc_rx == 16'h0000) ? crcdf_pkg::STATUS_OK
                                                                : crcdf_pkg::STATUS_CRC_BAD;
                end
                else
                begin
                    bytes_left_next = length_reg;
                    phase_next      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                running_crc_next  = crc_calc;
                bytes_left_next   = bytes_left_reg - 16'd1;
                emit_raw          = 1'b1;
                result.out_byte   = item_byte;
                result.byte_valid = 1'b1;
                // last payload byte closes the frame
                if (bytes_left_reg == 16'd1)
                begin
                    phase_next          = PH_HUNT;
                    marker_count_next   = 2'd0;
                    result.frame_end    = 1'b1;
                    result.frame_status = (crc_calc == received_crc_reg)
                                          ? crcdf_pkg::STATUS_OK : crcdf_pkg::STATUS_CRC_BAD;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            marker_count_reg <= 2'd0;
            topic_reg        <= 8'h00;
            seq_reg          <= 8'h00;
            length_reg       <= 16'h0000;
            received_crc_reg <= 16'h0000;
            running_crc_reg  <= 16'h0000;
            bytes_left_reg   <= 16'h0000;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            marker_count_reg <= marker_count_next;
            topic_reg        <= topic_next;
            seq_reg          <= seq_next;
            length_reg       <= length_next;
            received_crc_reg <= received_crc_next;
            running_crc_reg  <= running_crc_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= crcdf_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    `CRCDF_ASSERT_IMP(a_marker_range, clk, rst_n, 1'b1, marker_count_reg != 2'd3)
    `CRCDF_ASSERT_IMP(a_payload_left, clk, rst_n, phase_reg == PH_PAYLOAD,
                      bytes_left_reg != 16'd0)
    `CRCDF_ASSERT_NXT(a_end_rehunt, clk, rst_n, take && emit && result.frame_end,
                      phase_reg == PH_HUNT && marker_count_reg == 2'd0)
    `CRCDF_ASSERT_IMP(a_mid_is_data, clk, rst_n, emit && !result.frame_end,
                      result.byte_valid)

endmodule

// ----- src/crcdf_out_stage.sv -----
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module crcdf_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  crcdf_pkg::result_t load_data,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output crcdf_pkg::result_t out_data
);

    logic               valid_reg;
    crcdf_pkg::result_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ----- sim/crc16_checked_frame_deframer_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches both channels and the max_payload write port, runs its own model of
// the marker hunt, header capture and CRC-16/ARC over the payload, and checks
// every result item field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module crc16_checked_frame_deframer_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        frame_end,
    input  logic [1:0]  frame_status,
    input  logic [7:0]  frame_topic,
    input  logic [7:0]  sequence_res,
    input  logic [15:0] frame_len,
    output int          fail_count,
    output int          outstanding
);

    typedef enum logic [2:0] {
        HUNT,
        GET_TOPIC,
        GET_SEQ,
        GET_LEN_HI,
        GET_LEN_LO,
        GET_CRC_HI,
        GET_CRC_LO,
        IN_PAYLOAD
    } deframe_phase_t;

    deframe_phase_t     phase;
    logic [1:0]         marks_seen;
    logic [7:0]         hdr_topic;
    logic [7:0]         hdr_seq;
    logic [15:0]        hdr_len;
    logic [15:0]        hdr_crc;
    logic [15:0]        payload_crc;
    logic [15:0]        remaining;
    logic [15:0]        size_limit;
    crcdf_pkg::result_t due_results[$];
    int                 mismatches = 0;

    // Reflected CRC-16, one bit at a time, LSB first.
    function automatic logic [15:0] arc_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ crcdf_pkg::CRC_POLY_REFL;
        end
        return c;
    endfunction

    task automatic push_result(input logic [7:0] data, input logic is_byte,
                               input logic is_end, input logic [1:0] status);
        crcdf_pkg::result_t r;
        r.out_byte       = data;
        r.byte_valid     = is_byte;
        r.frame_end      = is_end;
        r.frame_status   = is_end ? status : crcdf_pkg::STATUS_OK;
        r.frame_topic    = hdr_topic;
        r.sequence_res   = hdr_seq;
        r.frame_len      = hdr_len;
        due_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (phase)
            HUNT:
            begin
                if (b == crcdf_pkg::MARKER_BYTE)
                begin
                    marks_seen = marks_seen + 2'd1;
                    if (marks_seen == 2'd3)
                    begin
                        marks_seen = 2'd0;
                        phase      = GET_TOPIC;
                    end
                end
                else
                begin
                    marks_seen = 2'd0;
                end
            end
            GET_TOPIC:
            begin
                hdr_topic = b;
                phase     = GET_SEQ;
            end
            GET_SEQ:
            begin
                hdr_seq = b;
                phase   = GET_LEN_HI;
            end
            GET_LEN_HI:
            begin
                hdr_len = {b, 8'h00};
                phase   = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                hdr_len[7:0] = b;
                phase        = GET_CRC_HI;
            end
            GET_CRC_HI:
            begin
                hdr_crc = {b, 8'h00};
                phase   = GET_CRC_LO;
            end
            GET_CRC_LO:
            begin
                hdr_crc[7:0] = b;
                payload_crc  = 16'h0000;
                if (hdr_len > size_limit)
                begin
                    phase      = HUNT;
                    marks_seen = 2'd0;
                    push_result(8'h00, 1'b0, 1'b1, crcdf_pkg::STATUS_OVERSIZE);
                end
                else if (hdr_len == 16'd0)
                begin
                    phase      = HUNT;
                    marks_seen = 2'd0;
                    push_result(8'h00, 1'b0, 1'b1,
                                hdr_crc == 16'h0000 ? crcdf_pkg::STATUS_OK
                                                    : crcdf_pkg::STATUS_CRC_BAD);
                end
                else
                begin
                    remaining = hdr_len;
                    phase     = IN_PAYLOAD;
                end
            end
            default:
            begin
                payload_crc = arc_crc_byte(payload_crc, b);
                remaining   = remaining - 16'd1;
                if (remaining == 16'd0)
                begin
                    phase      = HUNT;
                    marks_seen = 2'd0;
                    push_result(b, 1'b1, 1'b1,
                                payload_crc == hdr_crc ? crcdf_pkg::STATUS_OK
                                                       : crcdf_pkg::STATUS_CRC_BAD);
                end
                else
                begin
                    push_result(b, 1'b1, 1'b0, crcdf_pkg::STATUS_OK);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crcdf_pkg::result_t want;
        if (!rst_n)
        begin
            phase       = HUNT;
            marks_seen  = 2'd0;
            hdr_topic   = 8'h00;
            hdr_seq     = 8'h00;
            hdr_len     = 16'h0000;
            hdr_crc     = 16'h0000;
            payload_crc = 16'h0000;
            remaining   = 16'h0000;
            size_limit  = crcdf_pkg::MAX_PAYLOAD_RST;
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                size_limit = cfg_wdata;
            if (in_valid && in_ready)
                deframe_byte(in_byte);
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual byte %0h bv %0b",
                             $time, out_byte, byte_valid);
                    $display("    end %0b status %0d topic %0h seq %0h len %0h",
                             frame_end, frame_status, frame_topic, sequence_res,
                             frame_len);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                    check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
                    check_field("frame_end", 16'(want.frame_end), 16'(frame_end));
                    check_field("frame_status", 16'(want.frame_status),
                                16'(frame_status));
                    check_field("frame_topic", 16'(want.frame_topic), 16'(frame_topic));
                    check_field("sequence_res", 16'(want.sequence_res),
                                16'(sequence_res));
                    check_field("frame_len", want.frame_len, frame_len);
                end
            end
            outstanding <= due_results.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ----- sim/tb_crc16_checked_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds marker/header/payload byte streams with random gaps and output
// stalls through several max_payload settings; the checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_crc16_checked_frame_deframer_unit;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 110;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [7:0]  frame_topic;
    logic [7:0]  sequence_res;
    logic [15:0] frame_len;

    int          fail_count;
    int          outstanding;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;
    logic [15:0] limit_now   = crcdf_pkg::MAX_PAYLOAD_RST;

    always #5 clk = ~clk;

    crc16_checked_frame_deframer_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .frame_end      (frame_end),
        .frame_status   (frame_status),
        .frame_topic    (frame_topic),
        .sequence_res   (sequence_res),
        .frame_len      (frame_len)
    );

    crc16_checked_frame_deframer_unit_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .frame_end      (frame_end),
        .frame_status   (frame_status),
        .frame_topic    (frame_topic),
        .sequence_res   (sequence_res),
        .frame_len      (frame_len),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Mostly short payloads; never above the current limit.
    function automatic logic [15:0] pick_len();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 10)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 12);
        else
            n = $urandom_range(13, 64);
        if (n > 32'(limit_now))
            n = 32'(limit_now);
        return n[15:0];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Header claims len bytes; only n_body random payload bytes follow.
    task automatic send_frame(input logic [7:0] topic, input logic [7:0] seq,
                              input logic [15:0] len, input bit corrupt,
                              input int unsigned n_body);
        logic [7:0]  body[$];
        logic [15:0] crc;
        crc = 16'h0000;
        for (int i = 0; i < n_body; i++)
        begin
            body.push_back(8'($urandom_range(0, 255)));
            crc = crcdf_pkg::crc16_step(crc, body[i]);
        end
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        repeat (3) send_byte(crcdf_pkg::MARKER_BYTE);
        send_byte(topic);
        send_byte(seq);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    // Write max_payload once nothing is in flight.
    task automatic set_limit(input logic [15:0] v);
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        limit_now = v;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_crc16_checked_frame_deframer_unit NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : result_sink
        int unsigned gap;
        wait (rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : byte_source
        int unsigned pick;
        int unsigned cnt;
        int          phase_start;
        logic [15:0] len;
        logic [7:0]  b;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // broken marker, then '>' as topic with an empty frame
        send_byte(crcdf_pkg::MARKER_BYTE);
        send_byte(crcdf_pkg::MARKER_BYTE);
        send_byte(8'h00);
        send_frame(crcdf_pkg::MARKER_BYTE, 8'hFF, 16'h0000, 1'b0, 0);
        // oversize at the top of the length range
        send_frame(8'h00, 8'h00, 16'hFFFF, 1'b1, 0);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                1: set_limit(16'h0000);
                2: set_limit(16'hFFFF);
                3: set_limit(16'd8);
                4: set_limit(16'($urandom_range(1, 64)));
                default: ;
            endcase
            phase_start = bytes_sent;
            while (bytes_sent < phase_start + PHASE_ITEMS)
            begin
                calm = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    len = pick_len();
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                               $urandom_range(0, 4) == 0, 32'(len));
                end
                else if (pick < 77 && limit_now != 16'hFFFF)
                begin
                    if ($urandom_range(0, 1) == 1)
                        len = limit_now + 16'd1;
                    else
                        len = 16'($urandom_range(int'(limit_now) + 1, 65535));
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                               $urandom_range(0, 1) == 1, 0);
                end
                else if (pick < 90)
                begin
                    cnt = $urandom_range(1, 6);
                    repeat (cnt)
                    begin
                        b = ($urandom_range(0, 1) == 1) ? crcdf_pkg::MARKER_BYTE
                                                        : 8'($urandom_range(0, 255));
                        send_byte(b);
                    end
                    // usually resync the hunt so the next frame lines up
                    if ($urandom_range(0, 3) != 0)
                        send_byte(8'h00);
                end
                else
                begin
                    // cut-off frame: the next frame's bytes land in its payload
                    len = pick_len();
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                               1'b0,
                               len < 16'd2 ? 32'd0 : $urandom_range(1, 32'(len) - 1));
                end
            end
        end

        // length exactly at the limit, then one above
        calm = 1'b0;
        set_limit(16'd96);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd96, 1'b0, 96);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd97, 1'b0, 0);
        set_limit(crcdf_pkg::MAX_PAYLOAD_RST);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd5, 1'b0, 5);

        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_crc16_checked_frame_deframer_unit OK");
        else
            $display("tb_crc16_checked_frame_deframer_unit NOT OK");
        $finish;
    end

endmodule

// ----- crc16_checked_frame_deframer_unit.f -----
+incdir+src
src/crcdf_pkg.sv
src/crcdf_in_stage.sv
src/crcdf_core.sv
src/crcdf_out_stage.sv
src/crc16_checked_frame_deframer_unit.sv
sim/crc16_checked_frame_deframer_unit_checker.sv
sim/tb_crc16_checked_frame_deframer_unit.sv
